@@ hw/rtl/csp_pkg.sv @@
// Shared types, widths and helpers of the cumulative shell profile block.
package csp_pkg;

  localparam int unsigned NUM_SHELLS_DEF = 16;
  localparam int unsigned WW             = 160;
  localparam int unsigned TW             = 110;
  localparam int unsigned RAD_W          = 24;
  localparam int unsigned PIX_W          = 32;
  localparam int unsigned SUM_W          = 48;
  localparam int unsigned CNT_W          = 24;
  localparam int unsigned SIG_W          = 16;
  localparam int unsigned BKG_W          = 32;
  localparam int unsigned PV_W           = 32;
  localparam int unsigned VAR_W          = 48;
  localparam int unsigned OIDX_W         = 6;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned Q_DEPTH        = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BKG_MEAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BKG_VAR  = 2'd2;
  localparam logic [SIG_W-1:0]     SIGMA_RST    = 16'd12288;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_DIVZERO = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [RAD_W-1:0]        radius;
    logic signed [PIX_W-1:0] count;
  } cmd_t;

  function automatic logic [WW-1:0] mag(input logic signed [WW-1:0] x);
    return x[WW-1] ? WW'(-x) : WW'(x);
  endfunction

endpackage

@@ hw/rtl/csp_front.sv @@
// Command front end: accept, decode and queue command words.
module csp_front (
  input  logic                            start_i,
  input  logic [1:0]                      func_i,
  input  logic [csp_pkg::RAD_W-1:0]       radius_sq_i,
  input  logic signed [csp_pkg::PIX_W-1:0] pixel_count_i,
  input  logic                            q_full_i,
  output logic                            busy_o,
  output logic                            push_o,
  output csp_pkg::cmd_t                   word_o
);

  logic          known;
  csp_pkg::op_e  op;

  always_comb begin
    known = 1'b1;
    op    = csp_pkg::OP_ADD;
    unique case (func_i)
      2'd0: op = csp_pkg::OP_ADD;
      2'd1: op = csp_pkg::OP_CLEAR;
      2'd2: op = csp_pkg::OP_READ;
      default: known = 1'b0;
    endcase
  end

  assign busy_o        = q_full_i;
  assign push_o        = start_i && !q_full_i && known;
  assign word_o.op     = op;
  assign word_o.radius = radius_sq_i;
  assign word_o.count  = pixel_count_i;

endmodule

@@ hw/rtl/csp_cmdq.sv @@
// Short command queue between front end and execution unit.
module csp_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csp_pkg::cmd_t word_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output csp_pkg::cmd_t word_o
);

  localparam int unsigned PW = (csp_pkg::Q_DEPTH > 1) ? $clog2(csp_pkg::Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(csp_pkg::Q_DEPTH + 1);

  csp_pkg::cmd_t   mem_q [csp_pkg::Q_DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(csp_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        mem_q[wptr_q] <= word_i;
        wptr_q <= (wptr_q == PW'(csp_pkg::Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(csp_pkg::Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/csp_mul.sv @@
// Shift-add signed multiplier, one partial product bit per cycle.
module csp_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [csp_pkg::WW-1:0] a_i,
  input  logic signed [csp_pkg::WW-1:0] b_i,
  output logic                          done_o,
  output logic signed [csp_pkg::WW-1:0] prod_o
);

  logic                   run_q, neg_q;
  logic [csp_pkg::WW-1:0] a_q, b_q, acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      neg_q <= 1'b0;
      a_q   <= '0;
      b_q   <= '0;
      acc_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      neg_q <= a_i[csp_pkg::WW-1] ^ b_i[csp_pkg::WW-1];
      a_q   <= csp_pkg::mag(a_i);
      b_q   <= csp_pkg::mag(b_i);
      acc_q <= '0;
    end else if (run_q) begin
      if (b_q == '0) begin
        run_q <= 1'b0;
      end else begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= a_q << 1;
        b_q <= b_q >> 1;
      end
    end
  end

  assign done_o = run_q && (b_q == '0);
  assign prod_o = neg_q ? $signed(-acc_q) : $signed(acc_q);

endmodule

@@ hw/rtl/csp_div.sv @@
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module csp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [csp_pkg::WW-1:0] num_i,
  input  logic signed [csp_pkg::WW-1:0] den_i,
  output logic                          done_o,
  output logic signed [csp_pkg::WW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(csp_pkg::WW + 1);

  logic                   run_q, neg_q;
  logic [CW-1:0]          cnt_q;
  logic [csp_pkg::WW-1:0] quo_q, rem_q, den_q;
  logic [csp_pkg::WW-1:0] rem_sh;
  logic                   fits;

  assign rem_sh = {rem_q[csp_pkg::WW-2:0], quo_q[csp_pkg::WW-1]};
  assign fits   = (rem_sh >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      neg_q <= 1'b0;
      cnt_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      den_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      neg_q <= num_i[csp_pkg::WW-1] ^ den_i[csp_pkg::WW-1];
      cnt_q <= CW'(csp_pkg::WW);
      quo_q <= csp_pkg::mag(num_i);
      den_q <= csp_pkg::mag(den_i);
      rem_q <= '0;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        rem_q <= fits ? rem_sh - den_q : rem_sh;
        quo_q <= {quo_q[csp_pkg::WW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign done_o = run_q && (cnt_q == '0);
  assign quo_o  = neg_q ? $signed(-quo_q) : $signed(quo_q);

endmodule

@@ hw/rtl/csp_back.sv @@
// Execution unit: shell stores, shell bounds, profile readout sequencer.
module csp_back #(
  parameter int unsigned NUM_SHELLS = csp_pkg::NUM_SHELLS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [csp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [csp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 q_valid_i,
  input  csp_pkg::cmd_t                        q_word_i,
  output logic                                 q_pop_o,
  output logic                                 res_valid_o,
  output logic [csp_pkg::OIDX_W-1:0]           shell_index_o,
  output logic signed [csp_pkg::SUM_W-1:0]     shell_sum_o,
  output logic [csp_pkg::CNT_W-1:0]            shell_points_o,
  output logic signed [csp_pkg::PV_W-1:0]      profile_value_o,
  output logic signed [csp_pkg::VAR_W-1:0]     profile_variance_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);

  localparam int unsigned WW  = csp_pkg::WW;
  localparam int unsigned TW  = csp_pkg::TW;
  localparam int unsigned IW  = (NUM_SHELLS > 1) ? $clog2(NUM_SHELLS) : 1;
  localparam int unsigned NSQ = NUM_SHELLS * NUM_SHELLS;
  localparam logic signed [WW-1:0] P_MAX = WW'(64'sh7FFF_FFFF);
  localparam logic signed [WW-1:0] P_MIN = -WW'(64'sh8000_0000);
  localparam logic signed [WW-1:0] V_MAX = WW'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [WW-1:0] V_MIN = -WW'(64'sh8000_0000_0000);

  typedef enum logic [4:0] {
    S_IDLE, S_PW2, S_PW3, S_S6, S_FILL, S_R2, S_R3, S_LHS, S_CMP,
    S_M, S_W, S_DEN, S_A, S_V, S_C, S_P, S_X0, S_X1, S_X2, S_Q, S_ZERO
  } state_e;

  function automatic logic signed [WW-1:0] sat(input logic signed [WW-1:0] x,
                                               input logic signed [WW-1:0] lo,
                                               input logic signed [WW-1:0] hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  state_e                         state_q;
  logic [csp_pkg::SIG_W-1:0]      sig_q;
  logic [csp_pkg::BKG_W-1:0]      bm_q, bv_q;
  logic                           thr_ok_q;
  logic [TW-1:0]                  thr_q [NUM_SHELLS];
  logic [TW-1:0]                  acc_q, dlt_q, s6_q, lhs_q;
  logic [IW-1:0]                  k_q, idx_q;
  logic [31:0]                    pw_q;
  csp_pkg::cmd_t                  cmd_q;
  logic [47:0]                    r2_q, r3lo_q, r3hi_q;
  logic signed [csp_pkg::SUM_W-1:0] sums_q [NUM_SHELLS];
  logic [csp_pkg::CNT_W-1:0]      cnts_q [NUM_SHELLS];
  logic signed [WW-1:0]           m_q, w_q, den_q, a_q, v_q, c_q, x_q;
  logic signed [csp_pkg::PV_W-1:0] p_q;

  logic signed [csp_pkg::SUM_W-1:0] sum_nxt [NUM_SHELLS];
  logic [csp_pkg::CNT_W-1:0]      cnt_nxt [NUM_SHELLS];
  logic signed [csp_pkg::SUM_W:0] sum_t [NUM_SHELLS];

  logic                           mul_start, mul_done, div_start, div_done;
  logic signed [WW-1:0]           mul_a, mul_b, mul_p, div_n, div_d, div_q;
  logic [47:0]                    s3_w;
  logic [csp_pkg::CNT_W-1:0]      nm_w, n_w;
  logic signed [csp_pkg::SUM_W-1:0] c_w;
  logic signed [WW-1:0]           cm16_w, c16_w, num_w;
  logic [55:0]                    nmbm_w, nbm_w;
  logic [47:0]                    nmnm_w, nn_w, nnm_w;
  logic signed [63:0]             pp_w;
  logic                           res_fire;

  assign nm_w   = cnts_q[NUM_SHELLS-1];
  assign n_w    = cnts_q[idx_q];
  assign c_w    = sums_q[idx_q];
  assign cm16_w = WW'(sums_q[NUM_SHELLS-1]) <<< 16;
  assign c16_w  = WW'(c_w) <<< 16;
  assign s3_w   = 48'(pw_q) * 48'(sig_q);
  assign nmbm_w = 56'(nm_w) * 56'(bm_q);
  assign nbm_w  = 56'(n_w) * 56'(bm_q);
  assign nmnm_w = 48'(nm_w) * 48'(nm_w);
  assign nn_w   = 48'(n_w) * 48'(n_w);
  assign nnm_w  = 48'(n_w) * 48'(nm_w);
  assign pp_w   = p_q * p_q;
  assign num_w  = (v_q <<< 48) + x_q - (mul_p <<< 25);
  assign q_pop_o = (state_q == S_IDLE);
  assign res_fire = ((state_q == S_IDLE) && q_valid_i && (q_word_i.op == csp_pkg::OP_CLEAR))
                 || (state_q == S_CMP) || ((state_q == S_Q) && div_done)
                 || (state_q == S_ZERO);

  always_comb begin
    for (int i = 0; i < NUM_SHELLS; i++) begin
      sum_t[i] = (csp_pkg::SUM_W+1)'(sums_q[i]) + (csp_pkg::SUM_W+1)'(cmd_q.count);
      if (sum_t[i][csp_pkg::SUM_W] != sum_t[i][csp_pkg::SUM_W-1]) begin
        sum_nxt[i] = sum_t[i][csp_pkg::SUM_W] ? {1'b1, {(csp_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(csp_pkg::SUM_W-1){1'b1}}};
      end else begin
        sum_nxt[i] = sum_t[i][csp_pkg::SUM_W-1:0];
      end
      cnt_nxt[i] = (cnts_q[i] == '1) ? cnts_q[i] : cnts_q[i] + 1'b1;
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = m_q;
    unique case (state_q)
      S_PW3: begin
        mul_start = 1'b1;
        mul_a     = WW'(s3_w);
        mul_b     = WW'(s3_w);
      end
      S_M: begin
        mul_start = 1'b1;
        mul_a     = WW'(nmnm_w);
        mul_b     = WW'(bv_q);
      end
      S_W: begin
        mul_start = mul_done && (m_q != '0);
        mul_a     = m_q;
        mul_b     = m_q;
      end
      S_A: begin
        mul_start = 1'b1;
        mul_a     = WW'(nn_w);
        mul_b     = WW'(bv_q);
      end
      S_V: begin
        mul_start = mul_done;
        mul_a     = WW'(nnm_w);
        mul_b     = WW'(bv_q);
      end
      S_C: begin
        div_start = mul_done;
        div_n     = a_q <<< 24;
      end
      S_X0: begin
        mul_start = 1'b1;
        mul_a     = w_q;
        mul_b     = WW'(pp_w);
      end
      S_X1: begin
        mul_start = mul_done;
        mul_a     = c_q;
        mul_b     = WW'(p_q);
      end
      S_X2: begin
        div_start = mul_done;
        div_n     = num_w;
        div_d     = den_q;
      end
      S_Q: div_d = den_q;
      default: ;
    endcase
  end

  csp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  csp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      sig_q              <= csp_pkg::SIGMA_RST;
      bm_q               <= '0;
      bv_q               <= '0;
      thr_ok_q           <= 1'b0;
      for (int i = 0; i < NUM_SHELLS; i++) begin
        thr_q[i]  <= '0;
        sums_q[i] <= '0;
        cnts_q[i] <= '0;
      end
      acc_q              <= '0;
      dlt_q              <= '0;
      s6_q               <= '0;
      lhs_q              <= '0;
      k_q                <= '0;
      idx_q              <= '0;
      pw_q               <= '0;
      cmd_q              <= '0;
      r2_q               <= '0;
      r3lo_q             <= '0;
      r3hi_q             <= '0;
      m_q                <= '0;
      w_q                <= '0;
      den_q              <= '0;
      a_q                <= '0;
      v_q                <= '0;
      c_q                <= '0;
      x_q                <= '0;
      p_q                <= '0;
      res_valid_o        <= 1'b0;
      shell_index_o      <= '0;
      shell_sum_o        <= '0;
      shell_points_o     <= '0;
      profile_value_o    <= '0;
      profile_variance_o <= '0;
      status_o           <= csp_pkg::ST_OK;
      last_o             <= 1'b0;
    end else begin
      res_valid_o <= res_fire;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          csp_pkg::CFG_SIGMA: begin
            sig_q    <= cfg_data_i[csp_pkg::SIG_W-1:0];
            thr_ok_q <= 1'b0;
          end
          csp_pkg::CFG_BKG_MEAN: bm_q <= cfg_data_i;
          csp_pkg::CFG_BKG_VAR:  bv_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cmd_q <= q_word_i;
            unique case (q_word_i.op)
              csp_pkg::OP_ADD: state_q <= thr_ok_q ? S_R2 : S_PW2;
              csp_pkg::OP_CLEAR: begin
                for (int i = 0; i < NUM_SHELLS; i++) begin
                  sums_q[i] <= '0;
                  cnts_q[i] <= '0;
                end
                shell_index_o      <= '0;
                shell_sum_o        <= '0;
                shell_points_o     <= '0;
                profile_value_o    <= '0;
                profile_variance_o <= '0;
                status_o           <= csp_pkg::ST_OK;
                last_o             <= 1'b1;
              end
              csp_pkg::OP_READ: state_q <= S_M;
              default: ;
            endcase
          end
        end
        S_PW2: begin
          pw_q    <= 32'(sig_q) * 32'(sig_q);
          state_q <= S_PW3;
        end
        S_PW3: state_q <= S_S6;
        S_S6: begin
          if (mul_done) begin
            s6_q    <= TW'(mul_p);
            acc_q   <= TW'(mul_p);
            dlt_q   <= TW'(mul_p) + (TW'(mul_p) << 1);
            k_q     <= '0;
            state_q <= S_FILL;
          end
        end
        S_FILL: begin
          thr_q[k_q] <= acc_q;
          acc_q      <= acc_q + dlt_q;
          dlt_q      <= dlt_q + (s6_q << 1);
          if (k_q == IW'(NUM_SHELLS - 1)) begin
            thr_ok_q <= 1'b1;
            state_q  <= S_R2;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_R2: begin
          r2_q    <= 48'(cmd_q.radius) * 48'(cmd_q.radius);
          state_q <= S_R3;
        end
        S_R3: begin
          r3lo_q  <= 48'(r2_q[23:0]) * 48'(cmd_q.radius);
          r3hi_q  <= 48'(r2_q[47:24]) * 48'(cmd_q.radius);
          state_q <= S_LHS;
        end
        S_LHS: begin
          lhs_q   <= (((TW'(r3hi_q) << 24) + TW'(r3lo_q)) * TW'(NSQ)) << 18;
          state_q <= S_CMP;
        end
        S_CMP: begin
          shell_index_o      <= '0;
          shell_sum_o        <= '0;
          shell_points_o     <= '0;
          profile_value_o    <= '0;
          profile_variance_o <= '0;
          last_o             <= 1'b1;
          if (lhs_q > thr_q[NUM_SHELLS-1]) begin
            status_o <= csp_pkg::ST_RANGE;
          end else begin
            status_o <= csp_pkg::ST_OK;
            for (int i = 0; i < NUM_SHELLS; i++) begin
              if (lhs_q <= thr_q[i]) begin
                sums_q[i] <= sum_nxt[i];
                cnts_q[i] <= cnt_nxt[i];
              end
            end
          end
          state_q <= S_IDLE;
        end
        S_M: begin
          m_q     <= cm16_w - WW'(nmbm_w);
          state_q <= S_W;
        end
        S_W: begin
          if (mul_done) begin
            w_q   <= cm16_w + mul_p;
            idx_q <= '0;
            state_q <= (m_q == '0) ? S_ZERO : S_DEN;
          end
        end
        S_DEN: begin
          if (mul_done) begin
            den_q   <= mul_p <<< 8;
            state_q <= S_A;
          end
        end
        S_A: begin
          a_q     <= c16_w - WW'(nbm_w);
          state_q <= S_V;
        end
        S_V: begin
          if (mul_done) begin
            v_q     <= c16_w + mul_p;
            state_q <= S_C;
          end
        end
        S_C: begin
          if (mul_done) begin
            c_q     <= c16_w + mul_p;
            state_q <= S_P;
          end
        end
        S_P: begin
          if (div_done) begin
            p_q     <= csp_pkg::PV_W'(sat(div_q, P_MIN, P_MAX));
            state_q <= S_X0;
          end
        end
        S_X0: state_q <= S_X1;
        S_X1: begin
          if (mul_done) begin
            x_q     <= mul_p;
            state_q <= S_X2;
          end
        end
        S_X2: begin
          if (mul_done) begin
            state_q <= S_Q;
          end
        end
        S_Q: begin
          if (div_done) begin
            shell_index_o      <= csp_pkg::OIDX_W'(idx_q);
            shell_sum_o        <= c_w;
            shell_points_o     <= n_w;
            profile_value_o    <= p_q;
            profile_variance_o <= csp_pkg::VAR_W'(sat(div_q, V_MIN, V_MAX));
            status_o           <= csp_pkg::ST_OK;
            last_o             <= (idx_q == IW'(NUM_SHELLS - 1));
            if (idx_q == IW'(NUM_SHELLS - 1)) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_A;
            end
          end
        end
        S_ZERO: begin
          shell_index_o      <= csp_pkg::OIDX_W'(idx_q);
          shell_sum_o        <= c_w;
          shell_points_o     <= n_w;
          profile_value_o    <= '0;
          profile_variance_o <= '0;
          status_o           <= csp_pkg::ST_DIVZERO;
          last_o             <= (idx_q == IW'(NUM_SHELLS - 1));
          if (idx_q == IW'(NUM_SHELLS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/cumulative_shell_profile_top.sv @@
// Top level of the cumulative shell profile block.
//
//  channel   direction  handshake              word
//  command   in         start, busy            func_i, radius_sq_i, pixel_count_i
//  config    in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//  result    out        res_valid_o (strobe)   shell_index_o .. last_o
//
//  Add: the execution unit checks the radius against the shell bounds; after an outer
//  radius write the first add also builds the shell bound table (serial multiplier).
//  Clear: handled straight from idle. Readout: per shell, two passes of the serial
//  divider and four passes of the serial multiplier.
//  Reset clears stores and bounds at once; busy rises only while the command queue
//  is full. Each result stands for one cycle; the receiver cannot stall.
module cumulative_shell_profile_top #(
  parameter int unsigned NUM_SHELLS = csp_pkg::NUM_SHELLS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           func_i,
  input  logic [csp_pkg::RAD_W-1:0]            radius_sq_i,
  input  logic signed [csp_pkg::PIX_W-1:0]     pixel_count_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [csp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [csp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                 res_valid_o,
  output logic [csp_pkg::OIDX_W-1:0]           shell_index_o,
  output logic signed [csp_pkg::SUM_W-1:0]     shell_sum_o,
  output logic [csp_pkg::CNT_W-1:0]            shell_points_o,
  output logic signed [csp_pkg::PV_W-1:0]      profile_value_o,
  output logic signed [csp_pkg::VAR_W-1:0]     profile_variance_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);

  logic          push, q_full, q_valid, q_pop;
  csp_pkg::cmd_t push_word, q_word;

  assign cfg_ready_o = 1'b1;

  csp_front u_front (
    .start_i       (start),
    .func_i        (func_i),
    .radius_sq_i   (radius_sq_i),
    .pixel_count_i (pixel_count_i),
    .q_full_i      (q_full),
    .busy_o        (busy),
    .push_o        (push),
    .word_o        (push_word)
  );

  csp_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .word_o  (q_word)
  );

  csp_back #(
    .NUM_SHELLS (NUM_SHELLS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .q_valid_i          (q_valid),
    .q_word_i           (q_word),
    .q_pop_o            (q_pop),
    .res_valid_o        (res_valid_o),
    .shell_index_o      (shell_index_o),
    .shell_sum_o        (shell_sum_o),
    .shell_points_o     (shell_points_o),
    .profile_value_o    (profile_value_o),
    .profile_variance_o (profile_variance_o),
    .status_o           (status_o),
    .last_o             (last_o)
  );

endmodule
